// File: rtl/lzc_pkg.sv
// lzc_pkg: shared constants, state encodings and status structs for the
// lz78 compressor. No dependencies.
package lzc_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int BYTE_W           = 8;
    localparam int LIMIT_W          = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // match engine states
    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_HCHK = 3'b010,
        M_DCHK = 3'b100
    } t_mstate;

    // top level sequencer states
    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_LOOK = 5'b00010,
        T_CODE = 5'b00100,
        T_TAIL = 5'b01000,
        T_FIN  = 5'b10000
    } t_tstate;

    // match engine status
    typedef struct packed {
        logic done;
        logic hit;
    } t_match_st;

    // packer status
    typedef struct packed {
        logic room;
        logic fin_ok;
    } t_pack_st;

endpackage

// File: rtl/lz78_compressor.sv
// lz78_compressor: top level, stream sequencer, dictionary counters and the
// limit register. Depends on lzc_pkg, lzc_match and lzc_packer.
//
// Usage: input words (i_in_byte, i_end_of_stream) enter on i_valid/o_ready;
// packed output words (o_out_byte, o_last_out) leave on o_valid/i_ready.
// One input word is worked on at a time. A lookup probes the hash slot
// memory and then the entry store; a free slot on the first read ends it
// without an entry store read, and a live entry that does not match moves
// the probe to the next slot. A word that extends the match returns to idle
// after the lookup, a word that ends a codeword passes the code state, and
// the end of stream adds the tail and final states, plus any wait on i_ready.
// The packer holds up to 27 bits and sends one byte per cycle; when the
// receiver stalls, the output register holds and the sequencer waits before
// adding more bits, so o_ready stays low until there is room.
// Reset is synchronous on i_rst_n; after it the hash slot memory is cleared
// one slot per cycle, all 2 * DICT_ENTRIES slots (8192 by default), with o_ready
// low. Later streams restart the dictionary by zeroing the fill count; a slot
// counts only if its entry is within the fill count and names it as home.
// The limit register resets to 4096; the user must drive i_dict_limit_we /
// i_dict_limit_wdata only while the block is idle; the block does not enforce it.
module lz78_compressor
    import lzc_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_in_byte,
    input  logic               i_end_of_stream,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_last_out,
    input  logic               i_dict_limit_we,
    input  logic [LIMIT_W-1:0] i_dict_limit_wdata
);

    localparam int IW   = $clog2(DICT_ENTRIES);
    localparam int KW   = IW + BYTE_W;
    localparam int LW   = $clog2(IW + 1);
    localparam int NW   = $clog2(KW + 1);
    localparam int CMPW = ((IW > LIMIT_W) ? IW : LIMIT_W) + 1;

    t_tstate           r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [IW-1:0]     r_count;
    logic [LW-1:0]     r_len;
    logic [IW-1:0]     r_midx;
    logic              r_mact;
    logic [IW-1:0]     r_prefix;
    logic [BYTE_W-1:0] r_c;
    logic              r_eos;

    logic              w_acc;
    logic [IW-1:0]     w_prefix;
    t_match_st         w_mst;
    logic [IW-1:0]     w_hit_idx;
    logic              w_clr_busy;
    logic              w_ins_ok;
    logic              w_ins;
    logic [CMPW-1:0]   w_next;
    logic              w_pow2;
    t_pack_st          w_pst;
    logic              w_load;
    logic              w_fin;
    logic [IW-1:0]     w_mask;
    logic [KW-1:0]     w_chunk;
    logic [NW-1:0]     w_len;

    assign o_ready  = (r_state == T_IDLE) && !w_clr_busy;
    assign w_acc    = i_valid && o_ready;
    assign w_prefix = r_mact ? r_midx : '0;

    // insert while count plus one is below both the limit and the store size
    assign w_next   = CMPW'(r_count) + 1'b1;
    assign w_ins_ok = (w_next < CMPW'(r_limit)) && (w_next < CMPW'(DICT_ENTRIES));
    assign w_ins    = (r_state == T_LOOK) && w_mst.done && !w_mst.hit && w_ins_ok;
    assign w_pow2   = (r_count != '0) && ((r_count & (r_count - 1'b1)) == '0);

    // index bits beyond the current width are dropped
    assign w_mask = ~({IW{1'b1}} << r_len);

    always_comb begin
        w_chunk = '0;
        w_len   = '0;
        if (r_state == T_CODE) begin
            w_chunk = {r_prefix & w_mask, r_c};
            w_len   = NW'(r_len) + NW'(BYTE_W);
        end else begin
            w_chunk = KW'(r_midx & w_mask);
            w_len   = NW'(r_len);
        end
    end

    assign w_load = w_pst.room && ((r_state == T_CODE) || (r_state == T_TAIL && r_mact));
    assign w_fin  = (r_state == T_FIN) && w_pst.fin_ok;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: if (w_acc) n_state = T_LOOK;
            T_LOOK: begin
                if (w_mst.done) begin
                    if (!w_mst.hit) begin
                        n_state = T_CODE;
                    end else if (r_eos) begin
                        n_state = T_TAIL;
                    end else begin
                        n_state = T_IDLE;
                    end
                end
            end
            T_CODE: begin
                if (w_pst.room) begin
                    n_state = r_eos ? T_TAIL : T_IDLE;
                end
            end
            T_TAIL: if (w_pst.room) n_state = T_FIN;
            T_FIN:  if (w_pst.fin_ok) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_len   <= '0;
            r_midx  <= '0;
            r_mact  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_dict_limit_we) begin
                r_limit <= i_dict_limit_wdata;
            end
            if (w_ins) begin
                r_count <= r_count + 1'b1;
                if (w_pow2) begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (r_state == T_LOOK && w_mst.done) begin
                if (w_mst.hit) begin
                    r_midx <= w_hit_idx;
                    r_mact <= 1'b1;
                end else begin
                    r_midx <= '0;
                    r_mact <= 1'b0;
                end
            end
            if (w_fin) begin
                r_count <= '0;
                r_len   <= '0;
                r_midx  <= '0;
                r_mact  <= 1'b0;
            end
        end
    end

    // latched input word
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_c      <= i_in_byte;
            r_eos    <= i_end_of_stream;
            r_prefix <= w_prefix;
        end
    end

    lzc_match #(
        .DICT_ENTRIES(DICT_ENTRIES)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc),
        .i_key     ({w_prefix, i_in_byte}),
        .i_count   (r_count),
        .i_ins     (w_ins),
        .i_ins_idx (w_next[IW-1:0]),
        .o_st      (w_mst),
        .o_hit_idx (w_hit_idx),
        .o_busy    (w_clr_busy)
    );

    lzc_packer #(
        .DICT_ENTRIES(DICT_ENTRIES)
    ) u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_chunk     (w_chunk),
        .i_len       (w_len),
        .i_fin       (w_fin),
        .i_out_ready (i_ready),
        .o_st        (w_pst),
        .o_valid     (o_valid),
        .o_byte      (o_out_byte),
        .o_last      (o_last_out)
    );

    // an accepted word blocks the input until its work is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !o_ready)
        else $error("input accepted while a word is in flight");

    // fill count stays inside the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) < CMPW'(DICT_ENTRIES))
        else $error("entry count out of range");

    // a live match always names an existing entry
    a_match_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mact |-> (r_midx != '0) && (r_midx <= r_count))
        else $error("match index past fill count");

    // bits are only merged when the accumulator has room
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load || w_fin) |-> w_pst.room)
        else $error("packer overrun");

endmodule

// File: rtl/lzc_match.sv
// lzc_match: dictionary lookup and insert engine built on two synchronous
// memories (hash slots and entry store). Depends on lzc_pkg.
module lzc_match
    import lzc_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [$clog2(DICT_ENTRIES)+BYTE_W-1:0] i_key,
    input  logic [$clog2(DICT_ENTRIES)-1:0]      i_count,
    input  logic                                 i_ins,
    input  logic [$clog2(DICT_ENTRIES)-1:0]      i_ins_idx,
    output t_match_st                            o_st,
    output logic [$clog2(DICT_ENTRIES)-1:0]      o_hit_idx,
    output logic                                 o_busy
);

    localparam int IW = $clog2(DICT_ENTRIES);
    localparam int KW = IW + BYTE_W;
    localparam int HW = IW + 1;
    localparam int HD = 1 << HW;
    localparam int DW = HW + KW;

    // hash slots hold an entry number, entry store holds home slot, prefix and byte
    logic [IW-1:0] r_slots [HD];
    logic [DW-1:0] r_dict  [DICT_ENTRIES];

    t_mstate       r_state, n_state;
    logic [HW-1:0] r_slot, n_slot;
    logic [KW-1:0] r_key;
    logic [IW-1:0] r_kidx;
    logic [IW-1:0] r_hq;
    logic [DW-1:0] r_dq;
    logic          r_clr_busy;
    logic [HW-1:0] r_clr_addr;
    logic [HW-1:0] w_hash;
    logic [HW-1:0] w_haddr;
    logic          w_empty;
    logic          w_home;
    logic          w_match;

    // fold the key into a slot address
    always_comb begin
        w_hash = '0;
        for (int b = 0; b < KW; b++) begin
            w_hash[b % HW] = w_hash[b % HW] ^ i_key[b];
        end
    end

    // slot is free if its number is zero or past the live fill count
    assign w_empty = (r_hq == '0) || (r_hq > i_count);
    // a live entry names this slot as its home, otherwise the slot is stale
    assign w_home  = (r_dq[DW-1:KW] == r_slot);
    assign w_match = (r_dq[KW-1:0] == r_key);

    // probe sequencing
    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        o_st     = '0;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_slot  = w_hash;
                    n_state = M_HCHK;
                end
            end
            M_HCHK: begin
                if (w_empty) begin
                    o_st.done = 1'b1;
                    n_state   = M_IDLE;
                end else begin
                    n_state = M_DCHK;
                end
            end
            M_DCHK: begin
                if (!w_home) begin
                    o_st.done = 1'b1;
                    n_state   = M_IDLE;
                end else if (w_match) begin
                    o_st.done = 1'b1;
                    o_st.hit  = 1'b1;
                    n_state   = M_IDLE;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = M_HCHK;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    assign w_haddr   = n_slot;
    assign o_hit_idx = r_kidx;
    assign o_busy    = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot clearing pass after reset, one slot per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // probe payload
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_start && r_state == M_IDLE) begin
            r_key <= i_key;
        end
        if (r_state == M_HCHK) begin
            r_kidx <= r_hq;
        end
    end

    // hash slot memory; insert lands on the free slot the miss stopped at
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_slots[r_clr_addr] <= '0;
        end else if (i_ins) begin
            r_slots[r_slot] <= i_ins_idx;
        end
        r_hq <= r_slots[w_haddr];
    end

    // entry store memory
    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            r_dict[i_ins_idx] <= {r_slot, r_key};
        end
        r_dq <= r_dict[r_hq];
    end

endmodule

// File: rtl/lzc_packer.sv
// lzc_packer: bit accumulator that packs msb-first codeword chunks lsb-first
// into bytes and holds the output register. Depends on lzc_pkg.
module lzc_packer
    import lzc_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_load,
    input  logic [$clog2(DICT_ENTRIES)+BYTE_W-1:0]          i_chunk,
    input  logic [$clog2($clog2(DICT_ENTRIES)+BYTE_W+1)-1:0] i_len,
    input  logic                                            i_fin,
    input  logic                                            i_out_ready,
    output t_pack_st                                        o_st,
    output logic                                            o_valid,
    output logic [BYTE_W-1:0]                               o_byte,
    output logic                                            o_last
);

    localparam int CKW = $clog2(DICT_ENTRIES) + BYTE_W;
    localparam int NW  = $clog2(CKW + 1);
    localparam int AW  = CKW + BYTE_W - 1;
    localparam int CNW = $clog2(AW + 1);

    logic [AW-1:0]     r_acc, n_acc;
    logic [CNW-1:0]    r_cnt, n_cnt;
    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_ol;
    logic              w_take;
    logic              w_drain;
    logic [CKW-1:0]    w_left;
    logic [CKW-1:0]    w_rev;
    logic [NW-1:0]     w_sh;
    logic [BYTE_W-1:0] w_fin_byte;

    assign w_take  = !r_ov || i_out_ready;
    assign w_drain = (r_cnt >= CNW'(BYTE_W)) && w_take;
    assign o_st.room   = (r_cnt < CNW'(BYTE_W));
    assign o_st.fin_ok = o_st.room && w_take;

    // left-align the chunk, then reverse so the first bit lands at bit 0
    assign w_sh   = NW'(CKW) - i_len;
    assign w_left = i_chunk << w_sh;
    always_comb begin
        for (int b = 0; b < CKW; b++) begin
            w_rev[b] = w_left[CKW-1-b];
        end
    end

    // final byte: leftover bits, marker above them, zeros above that
    assign w_fin_byte = r_acc[BYTE_W-1:0] | (BYTE_W'(1) << r_cnt[2:0]);

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_load) begin
            n_acc = r_acc | (AW'(w_rev) << r_cnt);
            n_cnt = r_cnt + CNW'(i_len);
        end else if (i_fin) begin
            n_acc = '0;
            n_cnt = '0;
        end else if (w_drain) begin
            n_acc = r_acc >> BYTE_W;
            n_cnt = r_cnt - CNW'(BYTE_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            if (i_fin || w_drain) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_fin) begin
            r_ob <= w_fin_byte;
            r_ol <= 1'b1;
        end else if (w_drain) begin
            r_ob <= r_acc[BYTE_W-1:0];
            r_ol <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

endmodule

// File: test/tb_lz78_compressor.sv
// tb_lz78_compressor: self-checking bench for the lz78 compressor, with a
// behavioral encoder predictor, random flow control and limit sweeps.
// Depends on lzc_pkg and the lz78_compressor rtl.
module tb_lz78_compressor
    import lzc_pkg::*;
();

    localparam int STORE_DEPTH = 4096;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         in_byte;
    logic               in_eos;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         out_byte;
    logic               out_last;
    logic               lim_we;
    logic [LIMIT_W-1:0] lim_wdata;

    // predictor state
    logic [20:0]        enc_dict [STORE_DEPTH];
    bit                 enc_dict_ok [STORE_DEPTH];
    int unsigned        enc_count;
    int unsigned        enc_match;
    bit                 enc_active;
    logic [7:0]         enc_bits;
    int unsigned        enc_nbits;
    int unsigned        enc_limit;

    t_in_word           send_q [$];
    t_out_word          expect_q [$];
    int                 n_errors;
    int                 n_checked;
    int                 n_streams;
    bit                 no_idle;
    bit                 hold_rx;
    int                 hold_left;
    bit                 phase_done;
    bit                 in_acc_seen;

    lz78_compressor i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_ready            (in_ready),
        .i_in_byte          (in_byte),
        .i_end_of_stream    (in_eos),
        .o_valid            (out_valid),
        .i_ready            (out_ready),
        .o_out_byte         (out_byte),
        .o_last_out         (out_last),
        .i_dict_limit_we    (lim_we),
        .i_dict_limit_wdata (lim_wdata)
    );

    always #6 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic void enc_clear();
        foreach (enc_dict_ok[k]) enc_dict_ok[k] = 0;
        enc_count  = 0;
        enc_match  = 0;
        enc_active = 0;
        enc_bits   = 0;
        enc_nbits  = 0;
    endfunction

    function automatic void enc_bit(bit b);
        t_out_word w;
        enc_bits[enc_nbits] = b;
        enc_nbits++;
        if (enc_nbits == 8) begin
            w.data = enc_bits;
            w.last = 1'b0;
            expect_q.insert(expect_q.size(), w);
            enc_bits  = 0;
            enc_nbits = 0;
        end
    endfunction

    function automatic int unsigned idx_width();
        int unsigned v;
        int unsigned len;
        len = 0;
        if (enc_count <= 1) return 0;
        v = enc_count - 1;
        while (v != 0) begin
            len++;
            v >>= 1;
        end
        return len;
    endfunction

    function automatic void enc_index(int unsigned idx);
        int unsigned len;
        len = idx_width();
        for (int i = len; i > 0; i--) enc_bit((idx >> (i - 1)) & 1);
    endfunction

    // encode one input word, pushing the packed bytes it produces
    function automatic void encode_word(t_in_word w);
        int unsigned prefix;
        int unsigned hit;
        t_out_word   o;
        prefix = enc_active ? enc_match : 0;
        hit = 0;
        for (int k = 1; k <= enc_count && k < STORE_DEPTH; k++)
            if (hit == 0 && enc_dict_ok[k] && enc_dict[k] == {prefix[12:0], w.data})
                hit = k;
        if (hit != 0) begin
            enc_match  = hit;
            enc_active = 1;
        end else begin
            if (enc_count + 1 < enc_limit && enc_count + 1 < STORE_DEPTH) begin
                enc_count++;
                enc_dict[enc_count]    = {prefix[12:0], w.data};
                enc_dict_ok[enc_count] = 1;
            end
            enc_index(prefix);
            for (int i = 7; i >= 0; i--) enc_bit(w.data[i]);
            enc_active = 0;
            enc_match  = 0;
        end
        if (w.eos) begin
            if (enc_active) enc_index(enc_match);
            o.data = enc_bits | (8'd1 << enc_nbits);
            o.last = 1'b1;
            expect_q.insert(expect_q.size(), o);
            enc_clear();
        end
    endfunction

    // input word accepted at the rising edge
    always @(posedge clk) begin
        if (!rst_n) begin
            in_acc_seen <= 1'b0;
        end else begin
            in_acc_seen <= in_valid && in_ready;
        end
    end

    // ---------------- driver ----------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_acc_seen) begin
                encode_word({in_byte, in_eos});
                send_q.delete(0);
            end
            if (!in_valid || in_acc_seen) begin
                if (send_q.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
                    in_valid <= 1'b1;
                    in_byte  <= send_q[0].data;
                    in_eos   <= send_q[0].eos;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver flow control, long hold counted here
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_rx) begin
                hold_rx   <= 1'b0;
                hold_left <= 300;
                out_ready <= 1'b0;
            end else begin
                out_ready <= no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        t_out_word exp_w;
        if (rst_n && out_valid && out_ready) begin
            if (expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected word %h last %b", out_byte, out_last);
            end else begin
                exp_w = expect_q[0];
                expect_q.delete(0);
                n_checked++;
                if (out_byte !== exp_w.data || out_last !== exp_w.last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %h/%b got %h/%b", exp_w.data,
                                 exp_w.last, out_byte, out_last);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_stream(int len, int alpha);
        t_in_word w;
        for (int i = 0; i < len; i++) begin
            w.data = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1));
            w.eos  = (i == len - 1);
            send_q.insert(send_q.size(), w);
        end
        n_streams++;
    endtask

    task automatic drain();
        while (send_q.size() > 0 || in_valid || expect_q.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_limit(int unsigned v);
        @(negedge clk);
        lim_we    <= 1'b1;
        lim_wdata <= LIMIT_W'(v);
        enc_limit  = v;
        @(negedge clk);
        lim_we    <= 1'b0;
    endtask

    initial begin
        t_in_word    w;
        int unsigned limits [6];
        clk = 0; rst_n = 0; in_valid = 0; in_byte = 0; in_eos = 0;
        out_ready = 0; lim_we = 0; lim_wdata = 0;
        n_errors = 0; n_checked = 0; n_streams = 0;
        no_idle = 0; hold_rx = 0; hold_left = 0;
        enc_limit = LIMIT_RESET;
        enc_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, repeats that build matches, single byte stream
        for (int i = 0; i < 12; i++) begin
            w.data = (i % 2) ? 8'hff : 8'h00;
            w.eos  = (i == 11);
            send_q.insert(send_q.size(), w);
        end
        w = {8'haa, 1'b1}; send_q.insert(send_q.size(), w);
        for (int i = 0; i < 8; i++) begin
            w.data = 8'h41; w.eos = (i == 7);
            send_q.insert(send_q.size(), w);
        end
        drain();

        // random streams under several limits; full stall with long hold
        limits = '{2, 3, 5, 8191, 17, 4096};
        foreach (limits[li]) begin
            set_limit(limits[li]);
            if (li == 3) begin
                no_idle = 1;
                hold_rx = 1;
            end
            for (int s = 0; s < 3; s++)
                queue_stream($urandom_range(5, 25), (s == 0) ? 256 : $urandom_range(2, 6));
            drain();
            no_idle = 0;
        end
        // long stream past power-of-two counts
        set_limit(4096);
        queue_stream(90, 3);
        drain();

        $display("covered %0d streams, %0d packed words checked, limits 2..8191",
                 n_streams, n_checked);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("mismatches: %0d", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #3000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
